FILE: sv/cosine_cutoff_with_derivative_core_defines.svh
// assertion macros shared by the cosine cutoff rtl
`ifndef COSINE_CUTOFF_WITH_DERIVATIVE_CORE_DEFINES_SVH
`define COSINE_CUTOFF_WITH_DERIVATIVE_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, masked during reset
`define CCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, masked during reset
`define CCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/ccd_pkg.sv
// shared constants, types and tables for the cosine cutoff pipeline
package ccd_pkg;

  localparam int unsigned DIST_WIDTH_DEF    = 24;
  localparam int unsigned CORDIC_STAGES_DEF = 18;
  localparam int unsigned ATAN_ENTRIES      = 24;

  localparam int unsigned RADIUS_W   = 24;
  localparam int unsigned INV_W      = 23;
  localparam int unsigned VALUE_W    = 17;
  localparam int unsigned SLOPE_W    = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  // cordic datapath widths (q2.30 with headroom)
  localparam int unsigned UNIT_W = 31;
  localparam int unsigned XY_W   = 33;
  localparam int unsigned Z_W    = 34;

  localparam logic [UNIT_W-1:0] ONE_Q30      = 31'h4000_0000;
  localparam logic [UNIT_W-1:0] HALF_ONE_Q30 = 31'h2000_0000;
  localparam logic [31:0]       PI_Q30       = 32'd3373259426;
  localparam logic [30:0]       HALF_PI_Q30  = 31'd1686629713;
  localparam logic [31:0]       GAIN_Q30     = 32'd652032874;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd1572864;
  localparam logic [INV_W-1:0]    INV_RESET    = 23'd699051;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUTOFF_RADIUS  = 2'd0,
    REG_INVERSE_CUTOFF = 2'd1
  } ccd_reg_e;

  // sideband that travels with each beat through the pipeline
  typedef struct packed {
    logic valid;
    logic in_range;
    logic mirror;
  } ccd_side_t;

  // atan(2^-i) in q2.30
  function automatic logic [31:0] atan_q30(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'd843314856;
      1:       v = 32'd497837829;
      2:       v = 32'd263043836;
      3:       v = 32'd133525158;
      4:       v = 32'd67021686;
      5:       v = 32'd33543515;
      6:       v = 32'd16775850;
      7:       v = 32'd8388437;
      8:       v = 32'd4194282;
      9:       v = 32'd2097149;
      10:      v = 32'd1048575;
      11:      v = 32'd524287;
      12:      v = 32'd262143;
      13:      v = 32'd131071;
      14:      v = 32'd65535;
      15:      v = 32'd32767;
      16:      v = 32'd16383;
      17:      v = 32'd8191;
      18:      v = 32'd4095;
      19:      v = 32'd2047;
      20:      v = 32'd1023;
      21:      v = 32'd511;
      22:      v = 32'd255;
      23:      v = 32'd127;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: sv/ccd_cordic.sv
// pipelined rotation-mode cordic, one register stage per iteration
module ccd_cordic #(
  parameter int unsigned STAGES = ccd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  ccd_pkg::ccd_side_t            side_i,
  input  logic [31:0]                   phi_i,
  output ccd_pkg::ccd_side_t            side_o,
  output logic [ccd_pkg::UNIT_W-1:0]    cos_o,
  output logic [ccd_pkg::UNIT_W-1:0]    sin_o
);
  import ccd_pkg::*;

  logic signed [XY_W-1:0] x_q [STAGES];
  logic signed [XY_W-1:0] y_q [STAGES];
  logic signed [Z_W-1:0]  z_q [STAGES];
  ccd_side_t              side_q [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    localparam logic signed [Z_W-1:0] ATAN = $signed({{(Z_W-32){1'b0}}, atan_q30(k)});
    logic signed [XY_W-1:0] x_in, y_in, x_d, y_d;
    logic signed [Z_W-1:0]  z_in, z_d;
    ccd_side_t              s_in;

    if (k == 0) begin : g_first
      assign x_in = $signed({{(XY_W-32){1'b0}}, GAIN_Q30});
      assign y_in = '0;
      assign z_in = $signed({{(Z_W-32){1'b0}}, phi_i});
      assign s_in = side_i;
    end else begin : g_rest
      assign x_in = x_q[k-1];
      assign y_in = y_q[k-1];
      assign z_in = z_q[k-1];
      assign s_in = side_q[k-1];
    end

    // floor shifts, direction from the sign of the residual angle
    always_comb begin
      if (!z_in[Z_W-1]) begin
        x_d = x_in - (y_in >>> k);
        y_d = y_in + (x_in >>> k);
        z_d = z_in - ATAN;
      end else begin
        x_d = x_in + (y_in >>> k);
        y_d = y_in - (x_in >>> k);
        z_d = z_in + ATAN;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[k] <= '0;
      end else if (en_i) begin
        side_q[k] <= s_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k] <= x_d;
        y_q[k] <= y_d;
        z_q[k] <= z_d;
      end
    end
  end

  // clamp to the unit interval
  function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [XY_W-1:0] v);
    logic [UNIT_W-1:0] r;
    if (v[XY_W-1]) begin
      r = '0;
    end else if (v[XY_W-2:0] > (XY_W-1)'(ONE_Q30)) begin
      r = ONE_Q30;
    end else begin
      r = v[UNIT_W-1:0];
    end
    return r;
  endfunction

  assign cos_o  = clamp_unit(x_q[STAGES-1]);
  assign sin_o  = clamp_unit(y_q[STAGES-1]);
  assign side_o = side_q[STAGES-1];

endmodule

FILE: sv/cosine_cutoff_with_derivative_core.sv
// top level of the pipelined cosine cutoff and its radial derivative
//
// usage
//   input channel  : one distance beat (unsigned q6.18) per in_valid_i/in_ready_o handshake
//   output channel : cutoff_value_o (q1.16), cutoff_slope_o (signed q3.20) and
//                    inside_cutoff_o per out_valid_o/out_ready_i handshake
//   config port    : cfg_we_i writes cfg_data_i into the register picked by cfg_index_i
//                    (0 cutoff radius, 1 inverse cutoff); other indexes are dropped;
//                    write only while no beat is in flight
// timing
//   latency  : CORDIC_STAGES + 9 cycles from input handshake to out_valid_o
//              (27 at the default 18 cordic stages)
//   throughput: one beat per cycle, set by the fully pipelined cordic, one stage
//               per iteration, and the pipelined multipliers before and after it
// reset: all valid bits clear, registers return to rc = 6.0 and 1/rc = 1/6
// stall: the whole pipeline advances together; a two-entry output stage
//   (output register plus skid) catches the beat in flight when out_ready_i drops,
//   so in_ready_o comes straight from a flop and nothing is lost or repeated
`include "cosine_cutoff_with_derivative_core_defines.svh"

module cosine_cutoff_with_derivative_core #(
  parameter int unsigned DIST_WIDTH    = ccd_pkg::DIST_WIDTH_DEF,
  parameter int unsigned CORDIC_STAGES = ccd_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ccd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ccd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [DIST_WIDTH-1:0]             distance_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ccd_pkg::VALUE_W-1:0]       cutoff_value_o,
  output logic signed [ccd_pkg::SLOPE_W-1:0] cutoff_slope_o,
  output logic                              inside_cutoff_o
);
  import ccd_pkg::*;

  localparam int unsigned PW = DIST_WIDTH + INV_W;
  localparam int unsigned SW = (PW + 1 > 41) ? PW + 1 : 41;
  localparam int unsigned CW = (DIST_WIDTH > RADIUS_W) ? DIST_WIDTH : RADIUS_W;

  // configuration registers
  logic [RADIUS_W-1:0] radius_q;
  logic [INV_W-1:0]    inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
      inv_q    <= INV_RESET;
    end else if (cfg_we_i) begin
      case (ccd_reg_e'(cfg_index_i))
        REG_CUTOFF_RADIUS:  radius_q <= cfg_data_i[RADIUS_W-1:0];
        REG_INVERSE_CUTOFF: inv_q    <= cfg_data_i[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // slope scale pi/(2 rc) in q.30, follows the reciprocal register
  logic [53:0] m_prod;
  logic [54:0] m_sum;
  logic [31:0] m_d, m_q;

  assign m_prod = HALF_PI_Q30 * inv_q;
  assign m_sum  = 55'(m_prod) + 55'(1 << 21);
  assign m_d    = m_sum[53:22];

  always_ff @(posedge clk_i) begin
    m_q <= m_d;
  end

  // whole pipeline advances unless the skid entry is occupied
  logic en;
  logic skid_v_q;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  // stage 1: input register and cutoff compare
  ccd_side_t             side1_d, side1_q;
  logic [DIST_WIDTH-1:0] dist1_q;

  always_comb begin
    side1_d          = '0;
    side1_d.valid    = in_valid_i;
    side1_d.in_range = (CW'(distance_i) <= CW'(radius_q));
  end

  // stage 2: r times 1/rc
  ccd_side_t    side2_q;
  logic [PW-1:0] prod2_q;

  // stage 3: angle fraction, clamp and mirror into the first quarter turn
  ccd_side_t         side3_d, side3_q;
  logic [SW-1:0]     t_sum, t_sh;
  logic [UNIT_W-1:0] t_val;
  logic [29:0]       u3_d, u3_q;

  always_comb begin
    t_sum          = SW'(prod2_q) + SW'(512);
    t_sh           = t_sum >> 10;
    t_val          = (t_sh > SW'(ONE_Q30)) ? ONE_Q30 : t_sh[UNIT_W-1:0];
    side3_d        = side2_q;
    side3_d.mirror = (t_val > HALF_ONE_Q30);
    u3_d           = side3_d.mirror ? 30'(ONE_Q30 - t_val) : t_val[29:0];
  end

  // stage 4: fraction times pi
  ccd_side_t   side4_q;
  logic [61:0] phip4_q;

  // stage 5: round to radians q2.30
  ccd_side_t   side5_q;
  logic [62:0] phi_sum;
  logic [31:0] phi5_q;

  assign phi_sum = 63'(phip4_q) + 63'(1 << 29);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q <= '0;
      side2_q <= '0;
      side3_q <= '0;
      side4_q <= '0;
      side5_q <= '0;
    end else if (en) begin
      side1_q <= side1_d;
      side2_q <= side1_q;
      side3_q <= side3_d;
      side4_q <= side3_q;
      side5_q <= side4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist1_q <= distance_i;
      prod2_q <= dist1_q * inv_q;
      u3_q    <= u3_d;
      phip4_q <= u3_q * PI_Q30;
      phi5_q  <= phi_sum[61:30];
    end
  end

  // cordic stages
  ccd_side_t         side_c;
  logic [UNIT_W-1:0] cos_c, sin_c;

  ccd_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .side_i (side5_q),
    .phi_i  (phi5_q),
    .side_o (side_c),
    .cos_o  (cos_c),
    .sin_o  (sin_c)
  );

  // post 1: cutoff value, cosine negated for the mirrored half
  ccd_side_t         side6_q;
  logic [31:0]       fc_sum;
  logic [VALUE_W-1:0] fc6_q;
  logic [UNIT_W-1:0] sin6_q;

  assign fc_sum = side_c.mirror ? (32'(ONE_Q30) - 32'(cos_c) + 32'h4000)
                                : (32'(ONE_Q30) + 32'(cos_c) + 32'h4000);

  // post 2: slope scale times sine
  ccd_side_t          side7_q;
  logic [62:0]        sp7_q;
  logic [VALUE_W-1:0] fc7_q;

  // post 3: round, saturate, negate, zero outside the cutoff
  logic [63:0]        mag_sum;
  logic [23:0]        mag_full, mag;
  logic [VALUE_W-1:0] pval_d, pval_q;
  logic [SLOPE_W-1:0] pslope_d, pslope_q;
  logic               pv_q, pin_q;

  always_comb begin
    mag_sum  = 64'(sp7_q) + 64'h80_0000_0000;
    mag_full = mag_sum[63:40];
    mag      = (mag_full > 24'h80_0000) ? 24'h80_0000 : mag_full;
    if (side7_q.in_range) begin
      pval_d   = fc7_q;
      pslope_d = SLOPE_W'(24'd0 - mag);
    end else begin
      pval_d   = '0;
      pslope_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side6_q <= '0;
      side7_q <= '0;
      pv_q    <= 1'b0;
    end else if (en) begin
      side6_q <= side_c;
      side7_q <= side6_q;
      pv_q    <= side7_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fc6_q    <= fc_sum[31:15];
      sin6_q   <= sin_c;
      sp7_q    <= m_q * sin6_q;
      fc7_q    <= fc6_q;
      pval_q   <= pval_d;
      pslope_q <= pslope_d;
      pin_q    <= side7_q.in_range;
    end
  end

  // output register plus skid entry
  logic               out_v_q;
  logic [VALUE_W-1:0] out_value_q, skid_value_q;
  logic [SLOPE_W-1:0] out_slope_q, skid_slope_q;
  logic               out_inside_q, skid_inside_q;
  logic               out_free;

  assign out_free = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_free) begin
      out_v_q  <= skid_v_q || pv_q;
      skid_v_q <= 1'b0;
    end else if (en && pv_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_v_q) begin
        out_value_q  <= skid_value_q;
        out_slope_q  <= skid_slope_q;
        out_inside_q <= skid_inside_q;
      end else begin
        out_value_q  <= pval_q;
        out_slope_q  <= pslope_q;
        out_inside_q <= pin_q;
      end
    end else if (en && pv_q) begin
      skid_value_q  <= pval_q;
      skid_slope_q  <= pslope_q;
      skid_inside_q <= pin_q;
    end
  end

  assign out_valid_o     = out_v_q;
  assign cutoff_value_o  = out_value_q;
  assign cutoff_slope_o  = $signed(out_slope_q);
  assign inside_cutoff_o = out_inside_q;

  // skid only fills behind a held output beat
  `CCD_ASSERT_NOW(a_skid_behind_out, skid_v_q, out_v_q, "skid full with empty output register")
  `CCD_ASSERT_NOW(a_skid_fill_cause, $rose(skid_v_q), $past(out_v_q && !out_ready_i),
                  "skid filled without an output stall")
  `CCD_ASSERT_NEXT(a_skid_holds, skid_v_q && !out_ready_i, skid_v_q,
                   "skid beat dropped while output stalled")
  // beyond the cutoff both results are zero, inside the slope is never positive
  `CCD_ASSERT_NOW(a_outside_zero, out_v_q && !out_inside_q,
                  out_value_q == '0 && out_slope_q == '0, "non-zero result beyond cutoff")
  `CCD_ASSERT_NOW(a_slope_sign, out_v_q && out_inside_q,
                  out_slope_q[SLOPE_W-1] || out_slope_q == '0, "positive slope inside cutoff")

endmodule
